// ===== design/lud_pkg.sv =====
// ----------------------------------------------------------------------------
// lud_pkg: shared types and constants of the lens undistortion remap block
// Field widths, register indexes and reset values, pipeline sizing and the
// saturation helper for normalized coordinates.
// ----------------------------------------------------------------------------
package lud_pkg;

   // item and result field widths
   localparam int ModeW  = 1;
   localparam int ColW   = 10;
   localparam int RowW   = 9;
   localparam int PixW   = 8;

   // register widths
   localparam int FocalW  = 19;
   localparam int CenterXW = 18;
   localparam int CenterYW = 17;
   localparam int CoefW   = 22;
   localparam int CsrIdxW = 3;
   localparam int CsrDataW = 22;

   // default image size
   localparam int DefImgWidth  = 1024;
   localparam int DefImgHeight = 512;

   // register reset values
   localparam logic [FocalW-1:0]   FocalXReset  = 19'd117415;
   localparam logic [FocalW-1:0]   FocalYReset  = 19'd117068;
   localparam logic [CenterXW-1:0] CenterXReset = 18'd94007;
   localparam logic [CenterYW-1:0] CenterYReset = 17'd63584;
   localparam logic signed [CoefW-1:0] K1Reset = -22'sd297175;
   localparam logic signed [CoefW-1:0] K2Reset = 22'sd77552;
   localparam logic signed [CoefW-1:0] P1Reset = 22'sd203;
   localparam logic signed [CoefW-1:0] P2Reset = 22'sd18;

   // register indexes
   typedef enum logic [CsrIdxW-1:0] {
      CSR_FOCAL_X = 3'd0,
      CSR_FOCAL_Y = 3'd1,
      CSR_CENTER_X = 3'd2,
      CSR_CENTER_Y = 3'd3,
      CSR_RADIAL_K1 = 3'd4,
      CSR_RADIAL_K2 = 3'd5,
      CSR_TANGENTIAL_P1 = 3'd6,
      CSR_TANGENTIAL_P2 = 3'd7
   } csr_index_type;

   // divider: magnitude of the offset, quotient bits, dividend bits below the point
   localparam int MagW     = 18;
   localparam int QuoW     = 24;
   localparam int DivSteps = QuoW;
   localparam int LowW     = 4;

   // result queue
   localparam int FifoDepth = 64;
   localparam int FifoAw    = $clog2(FifoDepth);

   // saturation bounds of normalized coordinates (Q3.20)
   localparam logic signed [QuoW-1:0] XyMaxPos = {1'b0, {(QuoW-1){1'b1}}};
   localparam logic signed [QuoW-1:0] XyMaxNeg = {1'b1, {(QuoW-1){1'b0}}};

   typedef struct packed {
      logic            mode;
      logic [ColW-1:0] col;
      logic [RowW-1:0] row;
      logic [PixW-1:0] pixel;
   } item_type;

   typedef struct packed {
      logic [PixW-1:0] value;
      logic            in_range;
   } res_type;

   // apply sign to quotient magnitude and clamp to Q3.20
   function automatic logic signed [QuoW-1:0] sat_xy(input logic [QuoW-1:0] quo,
                                                     input logic neg,
                                                     input logic ovf);
      logic signed [QuoW-1:0] res;
      if (!neg) begin
         res = (ovf || quo[QuoW-1]) ? XyMaxPos : $signed(quo);
      end else begin
         res = (ovf || (quo[QuoW-1] && (quo[QuoW-2:0] != '0))) ? XyMaxNeg
                                                               : -$signed(quo);
      end
      return res;
   endfunction

endpackage

// ===== design/lud_ifs.sv =====
// ----------------------------------------------------------------------------
// lud_ifs: valid/ready channels of the remap block
// Request channel carries load and query items, response channel results.
// ----------------------------------------------------------------------------
interface lud_req_if import lud_pkg::*; ();
   logic            valid;
   logic            ready;
   logic            mode;
   logic [ColW-1:0] col;
   logic [RowW-1:0] row;
   logic [PixW-1:0] pixel;

   modport source (output valid, output mode, output col, output row, output pixel,
                   input ready);
   modport sink (input valid, input mode, input col, input row, input pixel,
                 output ready);
endinterface

interface lud_rsp_if import lud_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [PixW-1:0] value;
   logic            in_range;

   modport source (output valid, output value, output in_range, input ready);
   modport sink (input valid, input value, input in_range, output ready);
endinterface

// ===== design/lens_undistort_bilinear_remap_top.sv =====
// ----------------------------------------------------------------------------
// lens_undistort_bilinear_remap_top: lens undistortion with bilinear remap
// Throughput: one item per cycle while the result queue has credit; the
//   one-bit-per-stage dividers and the four pixel banks (one per row/column
//   parity) each take one item every cycle.
// Loads write the image in request order with queries; they give no result.
// Reset: synchronous, clears valids and queue pointers, presets the registers.
// ----------------------------------------------------------------------------
module lens_undistort_bilinear_remap_top import lud_pkg::*; #(
   parameter int IMG_WIDTH  = DefImgWidth,
   parameter int IMG_HEIGHT = DefImgHeight
) (
   input  logic                clock,
   input  logic                reset,
   lud_req_if.sink             req_if,
   lud_rsp_if.source           rsp_if,
   input  logic                csr_wr_en,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   localparam int ColBits  = $clog2(IMG_WIDTH);
   localparam int RowBits  = $clog2(IMG_HEIGHT);
   localparam int ColHalfW = (ColBits > 1) ? ColBits - 1 : 1;
   localparam int RowHalfW = (RowBits > 1) ? RowBits - 1 : 1;
   localparam int BankAw   = RowHalfW + ColHalfW;
   localparam int BankDepth = 1 << BankAw;
   localparam int StX      = DivSteps;
   localparam int StMem    = StX + 11;
   localparam int StLast   = StX + 14;
   localparam int MetaLen  = StLast + 1;
   localparam logic signed [41:0] RadOne = 42'sd1048576;

   // ---------------- configuration registers ----------------
   logic [FocalW-1:0]   focal_x_ff, focal_y_ff;
   logic [CenterXW-1:0] center_x_ff;
   logic [CenterYW-1:0] center_y_ff;
   logic signed [CoefW-1:0] k1_ff, k2_ff, p1_ff, p2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= FocalXReset;
         focal_y_ff  <= FocalYReset;
         center_x_ff <= CenterXReset;
         center_y_ff <= CenterYReset;
         k1_ff <= K1Reset;
         k2_ff <= K2Reset;
         p1_ff <= P1Reset;
         p2_ff <= P2Reset;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_FOCAL_X:       focal_x_ff  <= csr_wdata[FocalW-1:0];
            CSR_FOCAL_Y:       focal_y_ff  <= csr_wdata[FocalW-1:0];
            CSR_CENTER_X:      center_x_ff <= csr_wdata[CenterXW-1:0];
            CSR_CENTER_Y:      center_y_ff <= csr_wdata[CenterYW-1:0];
            CSR_RADIAL_K1:     k1_ff <= $signed(csr_wdata[CoefW-1:0]);
            CSR_RADIAL_K2:     k2_ff <= $signed(csr_wdata[CoefW-1:0]);
            CSR_TANGENTIAL_P1: p1_ff <= $signed(csr_wdata[CoefW-1:0]);
            CSR_TANGENTIAL_P2: p2_ff <= $signed(csr_wdata[CoefW-1:0]);
            default: ;
         endcase
      end
   end

   // zero focal length divides as one
   logic [FocalW-1:0] fx_div, fy_div;
   assign fx_div = (focal_x_ff == '0) ? FocalW'(1) : focal_x_ff;
   assign fy_div = (focal_y_ff == '0) ? FocalW'(1) : focal_y_ff;

   // ---------------- flow control: credits for result queue ----------------
   logic [FifoAw:0] total_ff, total_in;
   logic            req_xfer, rsp_xfer;

   assign req_if.ready = (total_ff < (FifoAw+1)'(FifoDepth));
   assign req_xfer = req_if.valid && req_if.ready;
   assign rsp_xfer = rsp_if.valid && rsp_if.ready;

   always_comb begin
      total_in = total_ff;
      if (req_xfer && req_if.mode) total_in = total_in + 1'b1;
      if (rsp_xfer)                total_in = total_in - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

   // ---------------- item shift line ----------------
   item_type           meta_ff [0:MetaLen-1];
   logic [MetaLen-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[MetaLen-2:0], req_xfer};
      end
   end

   always_ff @(posedge clock) begin
      meta_ff[0] <= '{mode: req_if.mode, col: req_if.col, row: req_if.row,
                      pixel: req_if.pixel};
      for (int i = 1; i < MetaLen; i++) begin
         meta_ff[i] <= meta_ff[i-1];
      end
   end

   // ---------------- offset from principal point ----------------
   logic signed [18:0] dx_in;
   logic signed [17:0] dy_in;
   logic [MagW-1:0]    xmag_ff, ymag_ff;
   logic               xneg_ff, yneg_ff;

   assign dx_in = $signed({1'b0, req_if.col, 8'b0}) - $signed({1'b0, center_x_ff});
   assign dy_in = $signed({1'b0, req_if.row, 8'b0}) - $signed({1'b0, center_y_ff});

   always_ff @(posedge clock) begin
      xneg_ff <= dx_in[18];
      yneg_ff <= dy_in[17];
      xmag_ff <= dx_in[18] ? MagW'(-dx_in) : MagW'(dx_in);
      ymag_ff <= dy_in[17] ? MagW'(-dy_in) : MagW'(dy_in);
   end

   // ---------------- normalization dividers ----------------
   logic [QuoW-1:0] qx, qy;
   logic            nx, ny, ox, oy;

   lud_div u_div_x (
      .clock   (clock),
      .in_mag  (xmag_ff),
      .in_neg  (xneg_ff),
      .divisor (fx_div),
      .out_quo (qx),
      .out_neg (nx),
      .out_ovf (ox)
   );

   lud_div u_div_y (
      .clock   (clock),
      .in_mag  (ymag_ff),
      .in_neg  (yneg_ff),
      .divisor (fy_div),
      .out_quo (qy),
      .out_neg (ny),
      .out_ovf (oy)
   );

   // ---------------- distortion arithmetic ----------------
   logic signed [23:0] x_pipe_ff [1:7];
   logic signed [23:0] y_pipe_ff [1:7];
   logic signed [47:0] x2p_ff, y2p_ff, xyp_ff;
   logic signed [27:0] x2_ff, y2_ff, xy_ff;
   logic signed [28:0] r2_ff;
   logic signed [57:0] r4p_ff;
   logic signed [50:0] k1r2p_ff, pxa_ff, pyb_ff;
   logic signed [51:0] pxb_ff, pya_ff;
   logic signed [37:0] r4_ff;
   logic signed [30:0] k1t5_ff, k1t6_ff;
   logic signed [32:0] tx_pipe_ff [5:8];
   logic signed [32:0] ty_pipe_ff [5:8];
   logic signed [59:0] k2r4p_ff;
   logic signed [41:0] rad_ff;
   logic signed [65:0] xrp_ff, yrp_ff;
   logic signed [46:0] xd_ff, yd_ff;
   logic signed [66:0] uxp_ff, vyp_ff;

   // slices are floor shifts by 20
   logic signed [27:0] x2_in, y2_in, xy_in;
   logic signed [28:0] r2_in, x2_dbl, y2_dbl, xy_dbl_src;
   logic signed [29:0] sx_in, sy_in;
   logic signed [22:0] p1_dbl, p2_dbl;
   logic signed [30:0] pxa_sh, pyb_sh, k1t_in;
   logic signed [31:0] pxb_sh, pya_sh;
   logic signed [39:0] k2r4_sh;
   logic signed [45:0] xr_sh, yr_sh;
   logic signed [46:0] ux_sh, vy_sh;
   logic signed [19:0] fx_s, fy_s;
   logic signed [18:0] cx_s, cy_s;
   logic signed [47:0] ud_in, vd_in;

   assign x2_in  = x2p_ff[47:20];
   assign y2_in  = y2p_ff[47:20];
   assign xy_in  = xyp_ff[47:20];
   assign r2_in  = x2_in + y2_in;
   assign x2_dbl = {x2_ff, 1'b0};
   assign y2_dbl = {y2_ff, 1'b0};
   assign xy_dbl_src = xy_ff;
   assign sx_in  = r2_ff + x2_dbl;
   assign sy_in  = r2_ff + y2_dbl;
   assign p1_dbl = {p1_ff, 1'b0};
   assign p2_dbl = {p2_ff, 1'b0};
   assign pxa_sh = pxa_ff[50:20];
   assign pxb_sh = pxb_ff[51:20];
   assign pya_sh = pya_ff[51:20];
   assign pyb_sh = pyb_ff[50:20];
   assign k1t_in = k1r2p_ff[50:20];
   assign k2r4_sh = k2r4p_ff[59:20];
   assign xr_sh  = xrp_ff[65:20];
   assign yr_sh  = yrp_ff[65:20];
   assign ux_sh  = uxp_ff[66:20];
   assign vy_sh  = vyp_ff[66:20];
   assign fx_s   = {1'b0, focal_x_ff};
   assign fy_s   = {1'b0, focal_y_ff};
   assign cx_s   = {1'b0, center_x_ff};
   assign cy_s   = {2'b0, center_y_ff};
   assign ud_in  = ux_sh + cx_s;
   assign vd_in  = vy_sh + cy_s;

   always_ff @(posedge clock) begin
      // stage 1: signed, saturated coordinates
      x_pipe_ff[1] <= sat_xy(qx, nx, ox);
      y_pipe_ff[1] <= sat_xy(qy, ny, oy);
      for (int i = 2; i <= 7; i++) begin
         x_pipe_ff[i] <= x_pipe_ff[i-1];
         y_pipe_ff[i] <= y_pipe_ff[i-1];
      end
      // stage 2: squares and cross product
      x2p_ff <= x_pipe_ff[1] * x_pipe_ff[1];
      y2p_ff <= y_pipe_ff[1] * y_pipe_ff[1];
      xyp_ff <= x_pipe_ff[1] * y_pipe_ff[1];
      // stage 3: scale back, radius squared
      x2_ff <= x2_in;
      y2_ff <= y2_in;
      xy_ff <= xy_in;
      r2_ff <= r2_in;
      // stage 4: r^4, k1 term, tangential products
      r4p_ff   <= r2_ff * r2_ff;
      k1r2p_ff <= k1_ff * r2_ff;
      pxa_ff   <= p1_dbl * xy_dbl_src;
      pxb_ff   <= p2_ff * sx_in;
      pya_ff   <= p1_ff * sy_in;
      pyb_ff   <= p2_dbl * xy_dbl_src;
      // stage 5: scale back, tangential sums
      r4_ff   <= r4p_ff[57:20];
      k1t5_ff <= k1t_in;
      tx_pipe_ff[5] <= pxa_sh + pxb_sh;
      ty_pipe_ff[5] <= pya_sh + pyb_sh;
      for (int i = 6; i <= 8; i++) begin
         tx_pipe_ff[i] <= tx_pipe_ff[i-1];
         ty_pipe_ff[i] <= ty_pipe_ff[i-1];
      end
      // stage 6: k2 term
      k2r4p_ff <= k2_ff * r4_ff;
      k1t6_ff  <= k1t5_ff;
      // stage 7: radial factor
      rad_ff <= RadOne + k1t6_ff + k2r4_sh;
      // stage 8: radial scaling
      xrp_ff <= x_pipe_ff[7] * rad_ff;
      yrp_ff <= y_pipe_ff[7] * rad_ff;
      // stage 9: distorted normalized point
      xd_ff <= xr_sh + tx_pipe_ff[8];
      yd_ff <= yr_sh + ty_pipe_ff[8];
      // stage 10: back to pixel scale
      uxp_ff <= fx_s * xd_ff;
      vyp_ff <= fy_s * yd_ff;
   end

   // ---------------- stage 11: source coordinate, range check ----------------
   logic [ColBits-1:0] iu11_ff;
   logic [RowBits-1:0] iv11_ff;
   logic [7:0]         fu11_ff, fv11_ff;
   logic               inr11_ff;
   logic               u_ok, v_ok;

   assign u_ok = !ud_in[47] && ($unsigned(ud_in[46:8]) <= 39'(IMG_WIDTH - 2));
   assign v_ok = !vd_in[47] && ($unsigned(vd_in[46:8]) <= 39'(IMG_HEIGHT - 2));

   always_ff @(posedge clock) begin
      iu11_ff  <= ud_in[ColBits+7:8];
      iv11_ff  <= vd_in[RowBits+7:8];
      fu11_ff  <= ud_in[7:0];
      fv11_ff  <= vd_in[7:0];
      inr11_ff <= u_ok && v_ok;
   end

   // ---------------- pixel banks: one per row/column parity ----------------
   item_type            mem_item;
   logic                mem_query, mem_load;
   logic [RowHalfW-1:0] rh_base, rh_plus, ld_rh;
   logic [ColHalfW-1:0] ch_base, ch_plus, ld_ch;
   logic [1:0]          ld_bank;
   logic [3:0]          bank_wr_en;
   logic [BankAw-1:0]   bank_rd_addr [0:3];
   logic [PixW-1:0]     bank_rd_data [0:3];

   assign mem_item  = meta_ff[StMem];
   assign mem_query = vld_ff[StMem] && mem_item.mode;
   assign mem_load  = vld_ff[StMem] && !mem_item.mode
                      && (32'(mem_item.col) < IMG_WIDTH)
                      && (32'(mem_item.row) < IMG_HEIGHT);

   assign rh_base = RowHalfW'(iv11_ff >> 1);
   assign rh_plus = rh_base + RowHalfW'(iv11_ff[0]);
   assign ch_base = ColHalfW'(iu11_ff >> 1);
   assign ch_plus = ch_base + ColHalfW'(iu11_ff[0]);
   assign ld_rh   = RowHalfW'(mem_item.row >> 1);
   assign ld_ch   = ColHalfW'(mem_item.col >> 1);
   assign ld_bank = {mem_item.row[0], mem_item.col[0]};

   for (genvar b = 0; b < 4; b++) begin : g_bank
      // even parity bank takes the next pair when the base is odd
      assign bank_rd_addr[b] = {(b >= 2) ? rh_base : rh_plus,
                                (b % 2 == 1) ? ch_base : ch_plus};
      assign bank_wr_en[b] = mem_load && (ld_bank == 2'(b));

      lud_ram #(
         .Width (PixW),
         .Depth (BankDepth)
      ) u_bank (
         .clock   (clock),
         .wr_en   (bank_wr_en[b]),
         .wr_addr ({ld_rh, ld_ch}),
         .wr_data (mem_item.pixel),
         .rd_en   (mem_query),
         .rd_addr (bank_rd_addr[b]),
         .rd_data (bank_rd_data[b])
      );
   end

   // stage 12: bank data arrives, carry fractions
   logic [7:0] fu12_ff, fv12_ff;
   logic       iu0_12_ff, iv0_12_ff, inr12_ff;

   always_ff @(posedge clock) begin
      fu12_ff   <= fu11_ff;
      fv12_ff   <= fv11_ff;
      iu0_12_ff <= iu11_ff[0];
      iv0_12_ff <= iv11_ff[0];
      inr12_ff  <= inr11_ff;
   end

   // ---------------- stage 13: horizontal blends ----------------
   logic [PixW-1:0] pix_lt, pix_rt, pix_lb, pix_rb;
   logic [16:0]     top_sum, bot_sum, fu_inv;
   logic [PixW-1:0] top13_ff, bot13_ff;
   logic [7:0]      fv13_ff;
   logic            inr13_ff;

   assign pix_lt = bank_rd_data[{iv0_12_ff, iu0_12_ff}];
   assign pix_rt = bank_rd_data[{iv0_12_ff, ~iu0_12_ff}];
   assign pix_lb = bank_rd_data[{~iv0_12_ff, iu0_12_ff}];
   assign pix_rb = bank_rd_data[{~iv0_12_ff, ~iu0_12_ff}];
   assign fu_inv = 17'd256 - 17'(fu12_ff);
   assign top_sum = 17'(fu12_ff) * 17'(pix_rt) + fu_inv * 17'(pix_lt);
   assign bot_sum = 17'(fu12_ff) * 17'(pix_rb) + fu_inv * 17'(pix_lb);

   always_ff @(posedge clock) begin
      top13_ff  <= top_sum[15:8];
      bot13_ff  <= bot_sum[15:8];
      fv13_ff   <= fv12_ff;
      inr13_ff  <= inr12_ff;
   end

   // ---------------- stage 14: vertical blend ----------------
   logic [16:0] val_sum, fv_inv;
   res_type     res14_ff;

   assign fv_inv  = 17'd256 - 17'(fv13_ff);
   assign val_sum = 17'(fv13_ff) * 17'(bot13_ff) + fv_inv * 17'(top13_ff);

   always_ff @(posedge clock) begin
      res14_ff.value    <= inr13_ff ? val_sum[15:8] : '0;
      res14_ff.in_range <= inr13_ff;
   end

   // ---------------- result queue ----------------
   logic [FifoAw:0] wr_ptr_ff, rd_ptr_ff, fifo_count;
   logic            fifo_wr, rd_issue, rsp_valid_ff;
   res_type         fifo_rd_data;

   assign fifo_wr    = vld_ff[StLast] && meta_ff[StLast].mode;
   assign fifo_count = wr_ptr_ff - rd_ptr_ff;
   assign rd_issue   = (fifo_count != '0) && (!rsp_valid_ff || rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fifo_wr) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (rd_issue) begin
            rd_ptr_ff    <= rd_ptr_ff + 1'b1;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   lud_ram #(
      .Width ($bits(res_type)),
      .Depth (FifoDepth)
   ) u_res_fifo (
      .clock   (clock),
      .wr_en   (fifo_wr),
      .wr_addr (wr_ptr_ff[FifoAw-1:0]),
      .wr_data (res14_ff),
      .rd_en   (rd_issue),
      .rd_addr (rd_ptr_ff[FifoAw-1:0]),
      .rd_data (fifo_rd_data)
   );

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.value    = fifo_rd_data.value;
   assign rsp_if.in_range = fifo_rd_data.in_range;

   // ---------------- assertions ----------------
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_count <= (FifoAw+1)'(FifoDepth))
      else $error("result queue overflow");

   a_credit_cover: assert property (@(posedge clock) disable iff (reset)
      {1'b0, total_ff} >= ({1'b0, fifo_count} + (FifoAw+2)'(rsp_valid_ff)))
      else $error("credit count below queued results");

   a_issue_valid: assert property (@(posedge clock) disable iff (reset)
      rd_issue |=> rsp_if.valid)
      else $error("queue read did not present a result");

endmodule

// ===== design/lud_ram.sv =====
// ----------------------------------------------------------------------------
// lud_ram: generic simple dual-port RAM
// One write port, one read port, read data registered and held when idle.
// ----------------------------------------------------------------------------
module lud_ram #(
   parameter int Width = 8,
   parameter int Depth = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [0:Depth-1];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/lud_div.sv =====
// ----------------------------------------------------------------------------
// lud_div: pipelined restoring divider for coordinate normalization
// Computes (mag << 20) / divisor, one quotient bit per stage, with an
// overflow flag when the quotient does not fit in the quotient width.
// ----------------------------------------------------------------------------
module lud_div import lud_pkg::*; (
   input  logic              clock,
   input  logic [MagW-1:0]   in_mag,
   input  logic              in_neg,
   input  logic [FocalW-1:0] divisor,
   output logic [QuoW-1:0]   out_quo,
   output logic              out_neg,
   output logic              out_ovf
);

   logic [FocalW-1:0] rem_ff [0:DivSteps-1];
   logic [LowW-1:0]   low_ff [0:DivSteps-1];
   logic [QuoW-1:0]   quo_ff [0:DivSteps-1];
   logic [DivSteps-1:0] neg_ff;
   logic [DivSteps-1:0] ovf_ff;

   // quotient too wide when mag >= divisor * 16
   logic in_ovf;
   assign in_ovf = {{(FocalW+LowW-MagW){1'b0}}, in_mag} >= {divisor, {LowW{1'b0}}};

   for (genvar k = 0; k < DivSteps; k++) begin : g_step
      logic [FocalW-1:0] r_prev;
      logic [LowW-1:0]   l_prev;
      logic [QuoW-1:0]   q_prev;
      logic              n_prev;
      logic              o_prev;
      logic [FocalW:0]   trial;
      logic [FocalW:0]   diff;
      logic              ge;

      if (k == 0) begin : g_first
         assign r_prev = {{(FocalW-MagW+LowW){1'b0}}, in_mag[MagW-1:LowW]};
         assign l_prev = in_mag[LowW-1:0];
         assign q_prev = '0;
         assign n_prev = in_neg;
         assign o_prev = in_ovf;
      end else begin : g_next
         assign r_prev = rem_ff[k-1];
         assign l_prev = low_ff[k-1];
         assign q_prev = quo_ff[k-1];
         assign n_prev = neg_ff[k-1];
         assign o_prev = ovf_ff[k-1];
      end

      // shift in next dividend bit, trial subtract
      assign trial = {r_prev, l_prev[LowW-1]};
      assign diff  = trial - {1'b0, divisor};
      assign ge    = ~diff[FocalW];

      always_ff @(posedge clock) begin
         rem_ff[k] <= ge ? diff[FocalW-1:0] : trial[FocalW-1:0];
         low_ff[k] <= {l_prev[LowW-2:0], 1'b0};
         quo_ff[k] <= {q_prev[QuoW-2:0], ge};
         neg_ff[k] <= n_prev;
         ovf_ff[k] <= o_prev;
      end
   end

   assign out_quo = quo_ff[DivSteps-1];
   assign out_neg = neg_ff[DivSteps-1];
   assign out_ovf = ovf_ff[DivSteps-1];

endmodule

// ===== verif/lens_undistort_bilinear_remap_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lens_undistort_bilinear_remap_top_tb: self-checking bench of the remap block
// Loads source pixels and sends undistortion queries under several lens
// settings, predicts each interpolated result in fixed point and compares
// it field by field with what the block returns. Both channels stall at
// random; one long output hold-off backs the pipeline up into the input.
// ----------------------------------------------------------------------------
module lens_undistort_bilinear_remap_top_tb import lud_pkg::*; ();

   localparam int ImgW      = DefImgWidth;
   localparam int ImgH      = DefImgHeight;
   localparam int Drain     = 60;
   localparam int WdogLimit = 3000;
   localparam int HoldLen   = 400;

   // predicts query results from its own copy of the image and the lens setup
   class remap_scoreboard;
      longint   fx, fy, cx, cy, k1, k2, p1, p2;
      bit [7:0] img [ImgW*ImgH];
      res_type  pending_res [$];
      int       errors, loads, queries, hits, outside;

      function new();
         fx = FocalXReset;
         fy = FocalYReset;
         cx = CenterXReset;
         cy = CenterYReset;
         k1 = K1Reset;
         k2 = K2Reset;
         p1 = P1Reset;
         p2 = P2Reset;
      endfunction

      function void write_reg(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] d);
         case (csr_index_type'(idx))
            CSR_FOCAL_X:       fx = d[FocalW-1:0];
            CSR_FOCAL_Y:       fy = d[FocalW-1:0];
            CSR_CENTER_X:      cx = d[CenterXW-1:0];
            CSR_CENTER_Y:      cy = d[CenterYW-1:0];
            CSR_RADIAL_K1:     k1 = $signed(d[CoefW-1:0]);
            CSR_RADIAL_K2:     k2 = $signed(d[CoefW-1:0]);
            CSR_TANGENTIAL_P1: p1 = $signed(d[CoefW-1:0]);
            default:           p2 = $signed(d[CoefW-1:0]);
         endcase
      endfunction

      // offset over focal length in Q3.20, truncated toward zero, saturated
      function longint normalize(longint d, longint f);
         longint q;
         if (f == 0) f = 1;
         q = (d <<< 20) / f;
         if (q > (64'sd1 <<< 23) - 1) q = (64'sd1 <<< 23) - 1;
         if (q < -(64'sd1 <<< 23)) q = -(64'sd1 <<< 23);
         return q;
      endfunction

      // source coordinate of an output pixel: integer part and fraction
      function void map_coord(int col, int row, output bit ok,
                              output longint iu, output longint iv,
                              output longint fu, output longint fv);
         longint x, y, x2, y2, xy, r2, r4, rad, xd, yd, ud, vd;
         x   = normalize(longint'(col) * 256 - cx, fx);
         y   = normalize(longint'(row) * 256 - cy, fy);
         x2  = (x * x) >>> 20;
         y2  = (y * y) >>> 20;
         xy  = (x * y) >>> 20;
         r2  = x2 + y2;
         r4  = (r2 * r2) >>> 20;
         rad = (64'sd1 <<< 20) + ((k1 * r2) >>> 20) + ((k2 * r4) >>> 20);
         xd  = ((x * rad) >>> 20) + ((2 * p1 * xy) >>> 20) + ((p2 * (r2 + 2 * x2)) >>> 20);
         yd  = ((y * rad) >>> 20) + ((p1 * (r2 + 2 * y2)) >>> 20) + ((2 * p2 * xy) >>> 20);
         ud  = ((fx * xd) >>> 20) + cx;
         vd  = ((fy * yd) >>> 20) + cy;
         iu  = ud >>> 8;
         iv  = vd >>> 8;
         fu  = ud & 255;
         fv  = vd & 255;
         ok  = iu >= 0 && iu <= ImgW - 2 && iv >= 0 && iv <= ImgH - 2;
      endfunction

      function void note_input(item_type it);
         bit      ok;
         longint  iu, iv, fu, fv, top, bot;
         res_type r;
         if (!it.mode) begin
            loads++;
            if (it.col < ImgW && it.row < ImgH) img[it.row * ImgW + it.col] = it.pixel;
            return;
         end
         queries++;
         map_coord(it.col, it.row, ok, iu, iv, fu, fv);
         if (!ok) begin
            outside++;
            r.value    = '0;
            r.in_range = 1'b0;
         end else begin
            hits++;
            top = (fu * img[iv * ImgW + iu + 1] + (256 - fu) * img[iv * ImgW + iu]) >> 8;
            bot = (fu * img[(iv + 1) * ImgW + iu + 1]
                   + (256 - fu) * img[(iv + 1) * ImgW + iu]) >> 8;
            r.value    = PixW'(((fv * bot + (256 - fv) * top) >> 8) & 255);
            r.in_range = 1'b1;
         end
         pending_res.push_back(r);
      endfunction

      task report(string msg);
         errors++;
         $display("%0t ERROR %s", $realtime, msg);
      endtask

      task check_result(res_type got);
         res_type want;
         if (pending_res.size() == 0) begin
            report($sformatf("result with no query waiting: value %0d in_range %0b",
                             got.value, got.in_range));
            return;
         end
         want = pending_res.pop_front();
         if (got.value !== want.value)
            report($sformatf("value %0d, expected %0d", got.value, want.value));
         if (got.in_range !== want.in_range)
            report($sformatf("in_range %0b, expected %0b", got.in_range, want.in_range));
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   lud_req_if req_ch ();
   lud_rsp_if rsp_ch ();

   lens_undistort_bilinear_remap_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch.sink),
      .rsp_if    (rsp_ch.source),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   remap_scoreboard sb;
   bit       loaded [ImgW*ImgH];
   bit       idle_on;
   bit       hold_rx;
   int       quiet_cycles;
   int       sent_items;
   item_type seen_item;
   res_type  seen_res;

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // observe transfers and register writes, feed the scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            seen_item.mode  = req_ch.mode;
            seen_item.col   = req_ch.col;
            seen_item.row   = req_ch.row;
            seen_item.pixel = req_ch.pixel;
            sb.note_input(seen_item);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen_res.value    = rsp_ch.value;
            seen_res.in_range = rsp_ch.in_range;
            sb.check_result(seen_res);
         end
         if (csr_wr_en) sb.write_reg(csr_index, csr_wdata);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WdogLimit) begin
            $display("watchdog: no transfer for %0d cycles", WdogLimit);
            $display("FAIL lens_undistort_bilinear_remap_top");
            $finish;
         end
      end
   end

   // result receiver: random stalls, one long hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rx) begin
            rsp_ch.ready <= 1'b0;
            repeat (HoldLen) @(posedge clock);
            hold_rx = 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   task automatic send_item(bit m, int c, int r, int p);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 14);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode  <= m;
      req_ch.col   <= ColW'(c);
      req_ch.row   <= RowW'(r);
      req_ch.pixel <= PixW'(p);
      do @(posedge clock); while (!req_ch.ready);
      sent_items++;
   endtask

   task automatic send_load(int c, int r, int p);
      loaded[r * ImgW + c] = 1'b1;
      send_item(1'b0, c, r, p);
   endtask

   // query; the four source neighbors get loaded first if still empty
   task automatic send_query(int c, int r);
      bit     ok;
      longint iu, iv, fu, fv;
      sb.map_coord(c, r, ok, iu, iv, fu, fv);
      if (ok) begin
         for (int dr = 0; dr < 2; dr++)
            for (int dc = 0; dc < 2; dc++)
               if (!loaded[(iv + dr) * ImgW + iu + dc])
                  send_load(int'(iu + dc), int'(iv + dr), $urandom_range(0, 255));
      end
      send_item(1'b1, c, r, $urandom_range(0, 255));
   endtask

   // stop offering, wait for every result, then let trailing loads finish
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.pending_res.size() != 0) @(posedge clock);
      repeat (Drain) @(posedge clock);
   endtask

   // lens settings: zeros, register extremes, undistorted, realistic random
   task automatic set_lens(int kind);
      longint v [8];
      case (kind)
         1: v = '{0, 0, 0, 0, 0, 0, 0, 0};
         2: v = '{524287, 524287, 262143, 131071, 2097151, -2097152, -2097152, 2097151};
         3: v = '{256, 256, 0, 0, -2097152, 2097151, 2097151, -2097152};
         4: v = '{65536, 65536, 131072, 65536, 0, 0, 0, 0};
         default: begin
            v[0] = $urandom_range(60000, 200000);
            v[1] = $urandom_range(60000, 200000);
            v[2] = $urandom_range(30000, 230000);
            v[3] = $urandom_range(20000, 110000);
            v[4] = longint'($urandom_range(0, 800000)) - 400000;
            v[5] = longint'($urandom_range(0, 400000)) - 200000;
            v[6] = longint'($urandom_range(0, 10000)) - 5000;
            v[7] = longint'($urandom_range(0, 10000)) - 5000;
         end
      endcase
      for (int i = 0; i < 8; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= CsrDataW'(v[i]);
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // mostly queries clustered in a window so loaded pixels get reused;
   // n counts every transfer, neighbor loads included
   task automatic random_traffic(int n);
      int wc, wr, c, r, stop;
      wc = $urandom_range(0, ImgW - 48);
      wr = $urandom_range(0, ImgH - 24);
      stop = sent_items + n;
      while (sent_items < stop) begin
         if ($urandom_range(0, 4) == 0) begin
            c = wc + $urandom_range(0, 47);
            r = wr + $urandom_range(0, 23);
            if ($urandom_range(0, 1) == 0) begin
               c = $urandom_range(0, ImgW - 1);
               r = $urandom_range(0, ImgH - 1);
            end
            send_load(c, r, $urandom_range(0, 255));
         end else if ($urandom_range(0, 4) == 0) begin
            send_query($urandom_range(0, ImgW - 1), $urandom_range(0, ImgH - 1));
         end else begin
            send_query(wc + $urandom_range(0, 47), wr + $urandom_range(0, 23));
         end
      end
   endtask

   initial begin
      sb           = new();
      idle_on      = 1'b1;
      hold_rx      = 1'b0;
      quiet_cycles = 0;
      sent_items   = 0;
      csr_wr_en    = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      req_ch.valid = 1'b0;
      req_ch.mode  = 1'b0;
      req_ch.col   = '0;
      req_ch.row   = '0;
      req_ch.pixel = '0;
      reset        = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes under the reset lens setup
      send_load(0, 0, 0);
      send_load(ImgW - 1, ImgH - 1, 255);
      send_load(ImgW - 1, 0, 255);
      send_load(0, ImgH - 1, 0);
      send_query(0, 0);
      send_query(ImgW - 1, 0);
      send_query(0, ImgH - 1);
      send_query(ImgW - 1, ImgH - 1);
      send_query(367, 248);
      send_query(368, 249);
      send_query(512, 256);
      drain();

      // zero focal length collapses every query onto the principal point
      set_lens(1);
      send_query(0, 0);
      send_query(ImgW - 1, ImgH - 1);
      drain();

      // lens settings in turn; output hold-off in one, no idling in the last
      for (int ph = 2; ph <= 9; ph++) begin
         set_lens(ph);
         if (ph == 6) hold_rx = 1'b1;
         if (ph == 9) idle_on = 1'b0;
         random_traffic(ph < 5 ? 115 : 275);
         drain();
      end

      $display("covered %0d loads and %0d queries (%0d inside, %0d outside)",
               sb.loads, sb.queries, sb.hits, sb.outside);
      $display("over nine lens settings, register extremes and zero focal length included");
      if (sb.errors == 0) begin
         $display("PASS lens_undistort_bilinear_remap_top");
      end else begin
         $display("FAIL lens_undistort_bilinear_remap_top");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/lud_pkg.sv
design/lud_ifs.sv
design/lud_ram.sv
design/lud_div.sv
design/lens_undistort_bilinear_remap_top.sv
verif/lens_undistort_bilinear_remap_top_tb.sv
